// ----- rtl/bpc_pkg.sv -----
// shared widths, register codes and scale tables of the pressure compensation core
`timescale 1ns / 1ps
package bpc_pkg;

  // field and datapath widths
  localparam int RAW_W       = 24;
  localparam int CODE_W      = 3;
  localparam int RECIP_W     = 29;
  localparam int SCALE_SHIFT = 20;
  localparam int SC_W        = 32;
  localparam int FRAC        = 26;
  localparam int COEF_W      = 16;
  localparam int COEF_WIDE_W = 20;
  localparam int OS_W        = 6;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int PV_W        = COEF_W + SC_W;
  localparam int T1_W        = 48;
  localparam int T2_W        = T1_W + SC_W - FRAC;
  localparam int T3_W        = T2_W + SC_W - FRAC;
  localparam int SUM_W       = T3_W + 2;
  localparam int OUT_SHIFT   = 18;
  localparam int PA_W        = 32;
  localparam int IN_DATA_W   = 2 * RAW_W;
  localparam int PIPE_DEPTH  = 12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_OFFSET     = 3'd0,
    REG_COEF_PRESS_LIN  = 3'd1,
    REG_COEF_TEMP_LIN   = 3'd2,
    REG_COEF_CROSS      = 3'd3,
    REG_COEF_PRESS_SQ   = 3'd4,
    REG_COEF_CROSS_SQ   = 3'd5,
    REG_COEF_PRESS_CUBE = 3'd6,
    REG_OVERSAMPLE      = 3'd7
  } cfg_reg_t;

  // register values after reset
  localparam logic signed [COEF_WIDE_W-1:0] RST_COEF_OFFSET     = 20'sd80469;
  localparam logic signed [COEF_WIDE_W-1:0] RST_COEF_PRESS_LIN  = -20'sd54769;
  localparam logic signed [COEF_W-1:0]      RST_COEF_TEMP_LIN   = -16'sd2803;
  localparam logic signed [COEF_W-1:0]      RST_COEF_CROSS      = 16'sd1226;
  localparam logic signed [COEF_W-1:0]      RST_COEF_PRESS_SQ   = -16'sd10787;
  localparam logic signed [COEF_W-1:0]      RST_COEF_CROSS_SQ   = 16'sd183;
  localparam logic signed [COEF_W-1:0]      RST_COEF_PRESS_CUBE = -16'sd1603;
  localparam logic [OS_W-1:0]               RST_OVERSAMPLE      = 6'd29;

  // oversampling scale factors
  localparam logic [63:0] SCALE_0 = 64'd524288;
  localparam logic [63:0] SCALE_1 = 64'd1572864;
  localparam logic [63:0] SCALE_2 = 64'd3670016;
  localparam logic [63:0] SCALE_3 = 64'd7864320;
  localparam logic [63:0] SCALE_4 = 64'd253952;
  localparam logic [63:0] SCALE_5 = 64'd516096;
  localparam logic [63:0] SCALE_6 = 64'd1040384;
  localparam logic [63:0] SCALE_7 = 64'd2088960;

  // reciprocals round(2^46 / scale), halves up
  localparam logic [63:0] RECIP_NUM = 64'd1 << 46;
  localparam logic [RECIP_W-1:0] RECIP_0 = RECIP_W'((RECIP_NUM + SCALE_0 / 2) / SCALE_0);
  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((RECIP_NUM + SCALE_1 / 2) / SCALE_1);
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((RECIP_NUM + SCALE_2 / 2) / SCALE_2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((RECIP_NUM + SCALE_3 / 2) / SCALE_3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((RECIP_NUM + SCALE_4 / 2) / SCALE_4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((RECIP_NUM + SCALE_5 / 2) / SCALE_5);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((RECIP_NUM + SCALE_6 / 2) / SCALE_6);
  localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'((RECIP_NUM + SCALE_7 / 2) / SCALE_7);

  // reciprocal for an oversampling code
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [CODE_W-1:0] code);
    logic [RECIP_W-1:0] r;
    case (code)
      3'd0:    r = RECIP_0;
      3'd1:    r = RECIP_1;
      3'd2:    r = RECIP_2;
      3'd3:    r = RECIP_3;
      3'd4:    r = RECIP_4;
      3'd5:    r = RECIP_5;
      3'd6:    r = RECIP_6;
      3'd7:    r = RECIP_7;
      default: r = RECIP_0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/bpc_scale.sv -----
// two-stage raw reading scaler: reciprocal multiply, then rounding and clipping to Q5.26
`timescale 1ns / 1ps
module bpc_scale
  import bpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [RAW_W-1:0] raw,
  input  logic [CODE_W-1:0]       code,
  output logic signed [SC_W-1:0]  sc_r,
  output logic                    sat_r
);

  localparam int PROD_W = RAW_W + RECIP_W + 1;
  localparam int SH_W   = PROD_W - SCALE_SHIFT;
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (SCALE_SHIFT - 1);

  logic signed [RECIP_W:0]   recip;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [SH_W-1:0]    shifted;
  logic                      over_hi;
  logic                      over_lo;
  logic signed [SC_W-1:0]    sc_nxt;
  logic                      sat_nxt;

  // stage 1: raw times reciprocal
  assign recip    = $signed({1'b0, recip_lookup(code)});
  assign prod_nxt = raw * recip;

  // stage 2: round half away from zero, then clip to the Q5.26 range
  assign rnd_sum = prod_r + RND - PROD_W'(prod_r[PROD_W-1]);
  assign shifted = rnd_sum[PROD_W-1:SCALE_SHIFT];
  assign over_hi = ~shifted[SH_W-1] & (|shifted[SH_W-2:SC_W-1]);
  assign over_lo = shifted[SH_W-1] & ~(&shifted[SH_W-2:SC_W-1]);

  always_comb begin
    sat_nxt = over_hi | over_lo;
    if (over_hi) begin
      sc_nxt = {1'b0, {(SC_W-1){1'b1}}};
    end else if (over_lo) begin
      sc_nxt = {1'b1, {(SC_W-1){1'b0}}};
    end else begin
      sc_nxt = shifted[SC_W-1:0];
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      sc_r   <= sc_nxt;
      sat_r  <= sat_nxt;
    end
  end

endmodule

// ----- rtl/bpc_mulq.sv -----
// two-stage signed Q.26 multiplier built from two partial products, rounded half away from zero
`timescale 1ns / 1ps
module bpc_mulq
  import bpc_pkg::*;
#(
  parameter int AW = T1_W
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [AW-1:0]           a,
  input  logic signed [SC_W-1:0]         b,
  output logic signed [AW+SC_W-FRAC-1:0] q
);

  localparam int LW = AW / 2;
  localparam int HW = AW - LW;
  localparam int PW = AW + SC_W;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC - 1);

  logic signed [HW-1:0]      a_hi;
  logic signed [LW:0]        a_lo;
  logic signed [HW+SC_W-1:0] pp_hi_nxt;
  logic signed [HW+SC_W-1:0] pp_hi_r;
  logic signed [LW+SC_W:0]   pp_lo_nxt;
  logic signed [LW+SC_W:0]   pp_lo_r;
  logic                      neg_nxt;
  logic                      neg_r;
  logic signed [PW-1:0]      hi_ext;
  logic signed [PW-1:0]      lo_ext;
  logic signed [PW-1:0]      p_nxt;
  logic signed [PW-1:0]      p_r;

  // stage 1: upper and lower halves of a times b
  assign a_hi      = a[AW-1:LW];
  assign a_lo      = {1'b0, a[LW-1:0]};
  assign pp_hi_nxt = a_hi * b;
  assign pp_lo_nxt = a_lo * b;
  assign neg_nxt   = (a[AW-1] ^ b[SC_W-1]) & (|a) & (|b);

  // stage 2: recombine and add the rounding offset, one less for a negative product
  assign hi_ext = PW'(pp_hi_r);
  assign lo_ext = PW'(pp_lo_r);
  assign p_nxt  = (hi_ext <<< LW) + lo_ext + RND - PW'(neg_r);

  assign q = p_r[PW-1:FRAC];

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hi_r <= pp_hi_nxt;
      pp_lo_r <= pp_lo_nxt;
      neg_r   <= neg_nxt;
      p_r     <= p_nxt;
    end
  end

endmodule

// ----- rtl/baro_pressure_compensation_core.sv -----
// Barometric pressure compensation core, top level.
// Each request carries a raw pressure and a raw temperature reading; each gives one
// compensated pressure in pascal (signed Q23.8) together with a flag that is set when
// a scaled reading or the result was clipped. The datapath is a 12-stage pipeline of
// narrow multipliers (reciprocal scaling, coefficient products, then two rounds of
// split Q.26 products) and adders, so a request is taken every clock cycle while the
// pipeline is not held. When out_tready is low with a result waiting, the whole
// pipeline holds and in_tready drops in the same cycle. Coefficients and oversampling
// codes are read straight from the configuration registers, so write them only while
// the pipeline is empty.
`timescale 1ns / 1ps
module baro_pressure_compensation_core
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PA_W-1:0]       out_tdata,  // [31:0] pressure_pa
  output logic                  out_tuser,  // [0] saturated
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CAR_N  = 7;
  localparam int SH_W   = SUM_W - OUT_SHIFT;
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (OUT_SHIFT - 1);

  // values carried alongside the multiplier chain, stages 3 to 9
  typedef struct packed {
    logic signed [SC_W-1:0] psc;
    logic signed [SC_W-1:0] tsc;
    logic signed [PV_W-1:0] pv;
    logic                   sat;
  } carry_t;

  // configuration registers
  logic signed [COEF_WIDE_W-1:0] coef_offset_r;
  logic signed [COEF_WIDE_W-1:0] coef_press_lin_r;
  logic signed [COEF_W-1:0]      coef_temp_lin_r;
  logic signed [COEF_W-1:0]      coef_cross_r;
  logic signed [COEF_W-1:0]      coef_press_sq_r;
  logic signed [COEF_W-1:0]      coef_cross_sq_r;
  logic signed [COEF_W-1:0]      coef_press_cube_r;
  logic [OS_W-1:0]               oversample_r;

  // pipeline control
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_r;

  // stage signals
  logic signed [RAW_W-1:0]          raw_p;
  logic signed [RAW_W-1:0]          raw_t;
  logic signed [SC_W-1:0]           psc2;
  logic signed [SC_W-1:0]           tsc2;
  logic                             psat2;
  logic                             tsat2;
  carry_t                           car_nxt;
  carry_t                           car_r [CAR_N];
  logic signed [PV_W-1:0]           p30_nxt;
  logic signed [PV_W-1:0]           p30_r;
  logic signed [PV_W-1:0]           p21_nxt;
  logic signed [PV_W-1:0]           p21_r;
  logic signed [COEF_W+FRAC-1:0]    c20_q;
  logic signed [COEF_W+FRAC-1:0]    c11_q;
  logic signed [COEF_WIDE_W+FRAC-1:0] c10_q;
  logic signed [COEF_WIDE_W+FRAC-1:0] c00_q;
  logic signed [T1_W-1:0]           t1_nxt;
  logic signed [T1_W-1:0]           t1_r;
  logic signed [T1_W-1:0]           u1_nxt;
  logic signed [T1_W-1:0]           u1_r;
  logic signed [T2_W-1:0]           q_t1;
  logic signed [T2_W-1:0]           q_u1;
  logic signed [T2_W-1:0]           t2_nxt;
  logic signed [T2_W-1:0]           t2_r;
  logic signed [T2_W-1:0]           u2_r;
  logic signed [T3_W-1:0]           t3;
  logic signed [T3_W-1:0]           u3;
  logic signed [SUM_W-1:0]          suma_nxt;
  logic signed [SUM_W-1:0]          suma_r;
  logic signed [SUM_W-1:0]          sumb_nxt;
  logic signed [SUM_W-1:0]          sumb_r;
  logic                             sat10_r;
  logic signed [SUM_W-1:0]          sum_nxt;
  logic signed [SUM_W-1:0]          sum_r;
  logic                             sat11_r;
  logic signed [SUM_W-1:0]          rnd_sum;
  logic signed [SH_W-1:0]           shifted;
  logic                             over_hi;
  logic                             over_lo;
  logic signed [PA_W-1:0]           out_pa_nxt;
  logic signed [PA_W-1:0]           out_pa_r;
  logic                             out_sat_nxt;
  logic                             out_sat_r;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_offset_r     <= RST_COEF_OFFSET;
      coef_press_lin_r  <= RST_COEF_PRESS_LIN;
      coef_temp_lin_r   <= RST_COEF_TEMP_LIN;
      coef_cross_r      <= RST_COEF_CROSS;
      coef_press_sq_r   <= RST_COEF_PRESS_SQ;
      coef_cross_sq_r   <= RST_COEF_CROSS_SQ;
      coef_press_cube_r <= RST_COEF_PRESS_CUBE;
      oversample_r      <= RST_OVERSAMPLE;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_OFFSET:     coef_offset_r     <= cfg_wdata[COEF_WIDE_W-1:0];
        REG_COEF_PRESS_LIN:  coef_press_lin_r  <= cfg_wdata[COEF_WIDE_W-1:0];
        REG_COEF_TEMP_LIN:   coef_temp_lin_r   <= cfg_wdata[COEF_W-1:0];
        REG_COEF_CROSS:      coef_cross_r      <= cfg_wdata[COEF_W-1:0];
        REG_COEF_PRESS_SQ:   coef_press_sq_r   <= cfg_wdata[COEF_W-1:0];
        REG_COEF_CROSS_SQ:   coef_cross_sq_r   <= cfg_wdata[COEF_W-1:0];
        REG_COEF_PRESS_CUBE: coef_press_cube_r <= cfg_wdata[COEF_W-1:0];
        REG_OVERSAMPLE:      oversample_r      <= cfg_wdata[OS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // global advance: the pipe moves unless a finished result is held back
  assign en         = ~vld_r[PIPE_DEPTH-1] | out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];
  assign out_tdata  = out_pa_r;
  assign out_tuser  = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // stages 1 and 2: scale both readings to Q5.26
  assign raw_p = in_tdata[RAW_W-1:0];
  assign raw_t = in_tdata[IN_DATA_W-1:RAW_W];

  bpc_scale u_scale_p (
    .clk   (clk),
    .en    (en),
    .raw   (raw_p),
    .code  (oversample_r[CODE_W-1:0]),
    .sc_r  (psc2),
    .sat_r (psat2)
  );

  bpc_scale u_scale_t (
    .clk   (clk),
    .en    (en),
    .raw   (raw_t),
    .code  (oversample_r[OS_W-1:CODE_W]),
    .sc_r  (tsc2),
    .sat_r (tsat2)
  );

  // coefficients lifted to Q.26
  assign c20_q = {coef_press_sq_r, FRAC'(0)};
  assign c11_q = {coef_cross_r, FRAC'(0)};
  assign c10_q = {coef_press_lin_r, FRAC'(0)};
  assign c00_q = {coef_offset_r, FRAC'(0)};

  // stage 3: coefficient products, exact since coefficients are whole numbers
  always_comb begin
    car_nxt.psc = psc2;
    car_nxt.tsc = tsc2;
    car_nxt.pv  = coef_temp_lin_r * tsc2;
    car_nxt.sat = psat2 | tsat2;
  end
  assign p30_nxt = coef_press_cube_r * psc2;
  assign p21_nxt = coef_cross_sq_r * psc2;

  // stage 4: inner polynomial sums
  assign t1_nxt = T1_W'(c20_q) + p30_r;
  assign u1_nxt = T1_W'(c11_q) + p21_r;

  // stages 5 and 6: times the scaled pressure
  bpc_mulq #(.AW(T1_W)) u_mul_t1 (
    .clk (clk),
    .en  (en),
    .a   (t1_r),
    .b   (car_r[1].psc),
    .q   (q_t1)
  );

  bpc_mulq #(.AW(T1_W)) u_mul_u1 (
    .clk (clk),
    .en  (en),
    .a   (u1_r),
    .b   (car_r[1].psc),
    .q   (q_u1)
  );

  // stage 7: add the linear pressure term
  assign t2_nxt = T2_W'(c10_q) + q_t1;

  // stages 8 and 9: outer products with pressure and temperature
  bpc_mulq #(.AW(T2_W)) u_mul_t2 (
    .clk (clk),
    .en  (en),
    .a   (t2_r),
    .b   (car_r[4].psc),
    .q   (t3)
  );

  bpc_mulq #(.AW(T2_W)) u_mul_u2 (
    .clk (clk),
    .en  (en),
    .a   (u2_r),
    .b   (car_r[4].tsc),
    .q   (u3)
  );

  // stages 10 and 11: accumulate the four terms
  assign suma_nxt = SUM_W'(t3) + SUM_W'(u3);
  assign sumb_nxt = SUM_W'(c00_q) + SUM_W'(car_r[CAR_N-1].pv);
  assign sum_nxt  = suma_r + sumb_r;

  // stage 12: round to Q23.8 and clip to 32 bits
  assign rnd_sum = sum_r + RND - SUM_W'(sum_r[SUM_W-1]);
  assign shifted = rnd_sum[SUM_W-1:OUT_SHIFT];
  assign over_hi = ~shifted[SH_W-1] & (|shifted[SH_W-2:PA_W-1]);
  assign over_lo = shifted[SH_W-1] & ~(&shifted[SH_W-2:PA_W-1]);

  always_comb begin
    out_sat_nxt = sat11_r | over_hi | over_lo;
    if (over_hi) begin
      out_pa_nxt = {1'b0, {(PA_W-1){1'b1}}};
    end else if (over_lo) begin
      out_pa_nxt = {1'b1, {(PA_W-1){1'b0}}};
    end else begin
      out_pa_nxt = shifted[PA_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      car_r[0] <= car_nxt;
      for (int i = 1; i < CAR_N; i++) begin
        car_r[i] <= car_r[i-1];
      end
      p30_r     <= p30_nxt;
      p21_r     <= p21_nxt;
      t1_r      <= t1_nxt;
      u1_r      <= u1_nxt;
      t2_r      <= t2_nxt;
      u2_r      <= q_u1;
      suma_r    <= suma_nxt;
      sumb_r    <= sumb_nxt;
      sat10_r   <= car_r[CAR_N-1].sat;
      sum_r     <= sum_nxt;
      sat11_r   <= sat10_r;
      out_pa_r  <= out_pa_nxt;
      out_sat_r <= out_sat_nxt;
    end
  end

  // a held result freezes every stage's valid bit
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid chain moved during a stall");

  // an open input takes a request, or a bubble, into stage 1
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |=> vld_r[0] == $past(in_tvalid))
    else $error("stage 1 valid does not follow the accepted request");

  // without clipped scaling, the flag means the result sits at a range limit
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(en) && $past(vld_r[PIPE_DEPTH-2]) && !$past(sat11_r) && out_tuser
    |-> (out_tdata == 32'h7FFF_FFFF) || (out_tdata == 32'h8000_0000))
    else $error("saturation flag set on an unclipped result");

endmodule
